// ----- src/brp_pkg.sv -----
// brp_pkg: shared constants, state type and control structs for the breathing LED PWM block.
// No dependencies; imported by brp_rsp_if and all modules.
`timescale 1ns / 1ps
package brp_pkg;

   localparam int PWM_FRAME_MS   = 20;
   localparam int PERIOD_SLOW_MS = 4000;
   localparam int PERIOD_FAST_MS = 400;
   localparam int SPEED_MIN      = 1;
   localparam int SPEED_MAX      = 4096;

   localparam int PHASE_W   = 12;
   localparam int PWM_W     = 5;
   localparam int BRIGHT_W  = 5;
   localparam int SPEED_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = SPEED_W;

   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 12;
   localparam int DIV_CNT_W = 5;

   localparam int PERIOD_SPAN = PERIOD_SLOW_MS - PERIOD_FAST_MS;
   localparam int SPEED_SPAN  = SPEED_MAX - SPEED_MIN;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED  = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PER_CALC,
      ST_PER_DIV,
      ST_BRT_CALC,
      ST_BRT_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ----- src/brp_channels.sv -----
// brp_req_if / brp_rsp_if: valid/ready channels carrying one word each.
// Depends on brp_pkg for field widths.
`timescale 1ns / 1ps
interface brp_req_if;
   logic valid;
   logic ready;
   logic advance;
   logic restart;

   modport source (output valid, output advance, output restart, input ready);
   modport sink   (input valid, input advance, input restart, output ready);
endinterface

interface brp_rsp_if;
   import brp_pkg::*;
   logic                valid;
   logic                ready;
   logic                lamp_on;
   logic [BRIGHT_W-1:0] brightness;

   modport source (output valid, output lamp_on, output brightness, input ready);
   modport sink   (input valid, input lamp_on, input brightness, output ready);
endinterface

// ----- src/breathing_led_pwm_top.sv -----
// breathing_led_pwm_top: breathing LED driver with triangle profile and 20 ms PWM frame.
// Depends on brp_pkg, brp_channels (brp_req_if, brp_rsp_if) and brp_div.
//
// Usage: each word on req_chan is one millisecond tick (advance) or a re-evaluation,
// optionally with restart, which zeroes the phase and PWM counters. Every request
// word yields exactly one rsp_chan word: lamp_on and brightness (0..20 ms of duty).
// csr_we/csr_index/csr_wdata write enable (index 0) or speed (index 1, saturated
// to 1..4096); any such write made while idle clears both counters and recomputes the period,
// 4000 - (speed-1)*3600/4095 ms; req_chan.ready is low while it does so.
// Other indexes are ignored.
// The brightness division runs one quotient bit per cycle over 24 bits in brp_div;
// a new request word is taken only after the previous one has left the divider.
// The response sits in an output register: a new request is taken while it waits,
// and the next result is held back until the receiver takes the previous one.
// Reset: synchronous, active high; disabled, speed 1, period 4000 ms, counters zero,
// no response pending.
`timescale 1ns / 1ps
module breathing_led_pwm_top (
   input  logic                           clock,
   input  logic                           reset,
   brp_req_if.sink                        req_chan,
   brp_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [brp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [brp_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import brp_pkg::*;

   state_type            state_ff, state_in;
   logic                 enable_ff, enable_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [PHASE_W-1:0]   period_ff, period_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [PWM_W-1:0]     pwm_ff, pwm_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 lamp_ff, lamp_in;
   logic [BRIGHT_W-1:0]  bright_ff, bright_in;

   div_ctl_type          div_ctl;
   div_sts_type          div_sts;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quo;

   logic                 csr_hit;
   logic                 req_fire;
   logic                 rsp_load;
   logic [PHASE_W-1:0]   half;
   logic [PHASE_W-1:0]   tri_val;
   logic [PHASE_W:0]     phase_inc;
   logic [PWM_W:0]       pwm_inc;
   logic [SPEED_W-1:0]   speed_sat;
   logic [BRIGHT_W-1:0]  quo_bright;

   assign csr_hit   = csr_we && (csr_index == CSR_ENABLE || csr_index == CSR_SPEED);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign half      = period_ff >> 1;
   assign tri_val   = (phase_ff < half) ? phase_ff : PHASE_W'(period_ff - phase_ff);
   assign phase_inc = {1'b0, phase_ff} + 1'b1;
   assign pwm_inc   = {1'b0, pwm_ff} + 1'b1;
   assign quo_bright = div_quo[BRIGHT_W-1:0];

   always_comb begin
      speed_sat = csr_wdata;
      if (csr_wdata < SPEED_W'(SPEED_MIN))
         speed_sat = SPEED_W'(SPEED_MIN);
      else if (csr_wdata > SPEED_W'(SPEED_MAX))
         speed_sat = SPEED_W'(SPEED_MAX);
   end

   // divider operands: period scale or triangle times frame
   always_comb begin
      if (state_ff == ST_PER_CALC) begin
         div_num = DIV_NUM_W'(PHASE_W'(speed_ff - SPEED_W'(SPEED_MIN))
                   * DIV_NUM_W'(PERIOD_SPAN));
         div_den = DIV_DEN_W'(SPEED_SPAN);
      end else begin
         div_num = DIV_NUM_W'(tri_val * DIV_NUM_W'(PWM_FRAME_MS));
         div_den = DIV_DEN_W'(half);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_hit)
               state_in = ST_PER_CALC;
            else if (req_fire)
               state_in = ST_BRT_CALC;
         end
         ST_PER_CALC: state_in = ST_PER_DIV;
         ST_PER_DIV:  if (div_sts.done) state_in = ST_IDLE;
         ST_BRT_CALC: state_in = ST_BRT_DIV;
         ST_BRT_DIV:  if (div_sts.done) state_in = ST_OUT;
         ST_OUT:      if (rsp_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_ctl.start  = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_chan.ready = !csr_we;
         ST_PER_CALC: div_ctl.start = 1'b1;
         ST_BRT_CALC: div_ctl.start = 1'b1;
         ST_OUT:      rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      enable_in    = enable_ff;
      speed_in     = speed_ff;
      period_in    = period_ff;
      phase_in     = phase_ff;
      pwm_in       = pwm_ff;
      rsp_valid_in = rsp_valid_ff;
      lamp_in      = lamp_ff;
      bright_in    = bright_ff;

      if (rsp_valid_ff && rsp_chan.ready)
         rsp_valid_in = 1'b0;

      if (state_ff == ST_IDLE && csr_hit) begin
         if (csr_index == CSR_ENABLE)
            enable_in = csr_wdata[0];
         else
            speed_in = speed_sat;
         phase_in = '0;
         pwm_in   = '0;
      end else if (req_fire) begin
         if (req_chan.restart) begin
            phase_in = '0;
            pwm_in   = '0;
         end else if (req_chan.advance) begin
            phase_in = (phase_inc >= {1'b0, period_ff}) ? '0 : phase_inc[PHASE_W-1:0];
            pwm_in   = (pwm_inc >= (PWM_W+1)'(PWM_FRAME_MS)) ? '0 : pwm_inc[PWM_W-1:0];
         end
      end

      if (state_ff == ST_PER_DIV && div_sts.done)
         period_in = PHASE_W'(PERIOD_SLOW_MS) - div_quo[PHASE_W-1:0];

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         lamp_in      = enable_ff && (pwm_ff < quo_bright);
         bright_in    = enable_ff ? quo_bright : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         speed_ff     <= SPEED_W'(SPEED_MIN);
         period_ff    <= PHASE_W'(PERIOD_SLOW_MS);
         phase_ff     <= '0;
         pwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         speed_ff     <= speed_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         pwm_ff       <= pwm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lamp_ff   <= lamp_in;
      bright_ff <= bright_in;
   end

   brp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .numerator (div_num),
      .divisor   (div_den),
      .sts       (div_sts),
      .quotient  (div_quo)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.lamp_on    = lamp_ff;
   assign rsp_chan.brightness = bright_ff;

   a_period_range: assert property (@(posedge clock) disable iff (reset)
      period_ff >= PHASE_W'(PERIOD_FAST_MS) && period_ff <= PHASE_W'(PERIOD_SLOW_MS))
      else $error("period out of range");
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff < period_ff) else $error("phase beyond period");
   a_out_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("word issued outside output state");

endmodule

// ----- src/brp_div.sv -----
// brp_div: restoring divider, one quotient bit per cycle, shared by period and brightness.
// Depends on brp_pkg.
`timescale 1ns / 1ps
module brp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  brp_pkg::div_ctl_type           ctl,
   input  logic [brp_pkg::DIV_NUM_W-1:0]  numerator,
   input  logic [brp_pkg::DIV_DEN_W-1:0]  divisor,
   output brp_pkg::div_sts_type           sts,
   output logic [brp_pkg::DIV_NUM_W-1:0]  quotient
);
   import brp_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   assign shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         num_in  = numerator;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : shifted[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = num_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff) else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider busy with empty count");

endmodule

// ----- tb/tb_breathing_led_pwm_top.sv -----
// tb_breathing_led_pwm_top: self-checking bench for the breathing LED PWM driver.
// Predicts each response word from tick words and register writes, then checks them in order.
// Depends on brp_pkg, brp_channels and breathing_led_pwm_top.
`timescale 1ns / 1ps
module tb_breathing_led_pwm_top;
   import brp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      logic                lamp_on;
      logic [BRIGHT_W-1:0] brightness;
   } duty_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   brp_req_if req_if ();
   brp_rsp_if rsp_if ();

   breathing_led_pwm_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic                 lamp_enabled;
   logic [SPEED_W-1:0]   speed_set;
   logic [PHASE_W-1:0]   period_len;
   logic [PHASE_W-1:0]   phase_cnt;
   logic [PWM_W-1:0]     frame_cnt;

   duty_type duty_q[$];
   int    error_count;
   int    word_count;
   int    reg_writes;
   int    cycle_count;
   int    stall_left;
   bit    no_gaps;
   bit    no_stalls;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic duty_type next_duty(input logic adv, input logic rst);
      int       ph;
      int       fr;
      int       half;
      int       bright;
      duty_type d;
      ph = phase_cnt;
      fr = frame_cnt;
      if (rst) begin
         ph = 0;
         fr = 0;
      end else if (adv) begin
         ph = (ph + 1 >= int'(period_len)) ? 0 : ph + 1;
         fr = (fr + 1 >= PWM_FRAME_MS) ? 0 : fr + 1;
      end
      phase_cnt = ph[PHASE_W-1:0];
      frame_cnt = fr[PWM_W-1:0];
      half = int'(period_len) / 2;
      if (ph < half) begin
         bright = (ph * PWM_FRAME_MS) / half;
      end else begin
         bright = ((int'(period_len) - ph) * PWM_FRAME_MS) / half;
      end
      if (lamp_enabled) begin
         d.lamp_on    = (fr < bright);
         d.brightness = bright[BRIGHT_W-1:0];
      end else begin
         d.lamp_on    = 1'b0;
         d.brightness = '0;
      end
      return d;
   endfunction

   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      while (duty_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_word(input logic adv, input logic rst);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.advance <= adv;
      req_if.restart <= rst;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      duty_q.push_back(next_duty(adv, rst));
      word_count++;
   endtask

   task automatic send_ticks(input int count, input int restart_pct);
      repeat (count) begin
         send_word($urandom_range(0, 99) < 90, $urandom_range(0, 99) < restart_pct);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      int s;
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_writes++;
      if (idx == CSR_ENABLE || idx == CSR_SPEED) begin
         if (idx == CSR_ENABLE) begin
            lamp_enabled = data[0];
         end else begin
            s = data;
            if (s < SPEED_MIN) s = SPEED_MIN;
            if (s > SPEED_MAX) s = SPEED_MAX;
            speed_set = s[SPEED_W-1:0];
         end
         s = PERIOD_SLOW_MS - ((int'(speed_set) - SPEED_MIN) * PERIOD_SPAN) / SPEED_SPAN;
         period_len = s[PHASE_W-1:0];
         phase_cnt  = '0;
         frame_cnt  = '0;
      end
   endtask

   task automatic test_reset_state();
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b1);
   endtask

   task automatic test_enable_bit();
      write_reg(CSR_ENABLE, 13'h1FFE);
      send_word(1'b1, 1'b0);
      write_reg(CSR_SPEED, 13'h1FFF);
      write_reg(CSR_ENABLE, 13'h0001);
      repeat (6) send_word(1'b1, 1'b0);
   endtask

   task automatic test_ignored_index();
      write_reg(CSR_SPARE_2, 13'h1FFF);
      write_reg(CSR_SPARE_3, 13'h1FFF);
      repeat (2) send_word(1'b1, 1'b0);
   endtask

   task automatic test_speed_saturation();
      write_reg(CSR_SPEED, 13'd0);
      send_word(1'b1, 1'b0);
      write_reg(CSR_SPEED, 13'd4097);
      send_word(1'b1, 1'b0);
      write_reg(CSR_SPEED, 13'd4096);
      send_word(1'b1, 1'b0);
   endtask

   task automatic test_restart();
      send_word(1'b1, 1'b1);
      send_word(1'b0, 1'b1);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
   endtask

   // fastest period, long enough to wrap the whole triangle once
   task automatic test_full_breath();
      write_reg(CSR_SPEED, 13'd4096);
      write_reg(CSR_ENABLE, 13'd1);
      for (int i = 0; i < 460; i++) begin
         no_gaps   = (i < 150);
         no_stalls = (i < 150) || (i >= 300 && i < 340);
         if (i % 100 == 99) pause_until_drained();
         send_word($urandom_range(0, 99) < 92, 1'b0);
      end
      no_gaps   = 1'b0;
      no_stalls = 1'b0;
   endtask

   task automatic test_random_settings();
      logic [CSR_DAT_W-1:0] spd;
      for (int p = 0; p < 4; p++) begin
         case ($urandom_range(0, 4))
            0: spd = 13'd1;
            1: spd = 13'd4096;
            2: spd = 13'd0;
            3: spd = 13'($urandom_range(4097, 8191));
            default: spd = 13'($urandom_range(1, 4096));
         endcase
         write_reg(CSR_SPEED, spd);
         write_reg(CSR_ENABLE, 13'($urandom_range(0, 8191)) | 13'(p != 2));
         no_gaps = (p == 1);
         send_ticks(90, 3);
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin
      duty_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (duty_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word, lamp_on %0b brightness %0d", $time,
                        rsp_if.lamp_on, rsp_if.brightness);
            end else begin
               want = duty_q.pop_front();
               if (rsp_if.lamp_on !== want.lamp_on) begin
                  error_count++;
                  $display("%0t: lamp_on mismatch, expected %0b, actual %0b", $time,
                           want.lamp_on, rsp_if.lamp_on);
               end
               if (rsp_if.brightness !== want.brightness) begin
                  error_count++;
                  $display("%0t: brightness mismatch, expected %0d, actual %0d", $time,
                           want.brightness, rsp_if.brightness);
               end
            end
            stall_left = no_stalls ? 0 : $urandom_range(0, 15);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words pending", cycle_count, duty_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.advance <= 1'b0;
      req_if.restart <= 1'b0;
      cycle_count    <= 0;
      error_count  = 0;
      word_count   = 0;
      reg_writes   = 0;
      no_gaps      = 1'b0;
      no_stalls    = 1'b0;
      lamp_enabled = 1'b0;
      speed_set    = SPEED_W'(SPEED_MIN);
      period_len   = PHASE_W'(PERIOD_SLOW_MS);
      phase_cnt    = '0;
      frame_cnt    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_enable_bit();
      test_ignored_index();
      test_speed_saturation();
      test_restart();
      test_full_breath();
      test_random_settings();

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (duty_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected words never arrived", $time, duty_q.size());
      end
      $display("Checked %0d tick words across %0d register writes, including full breath",
               word_count, reg_writes);
      $display("cycles at the fastest period and saturated speeds; %0d errors", error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
